### rtl/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared constants for the lowest-free identifier allocator: operation codes,
// bitmap word geometry and the default table capacity.
// ----------------------------------------------------------------------------
package lfa_pkg;

  localparam int OP_W = 2;
  localparam int ID_W = 8;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // bitmap is kept in words of WORD_W bits, OFF_W bits select a bit in a word
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  localparam int DEF_CAPACITY = 256;

endpackage

### rtl/lfa_scan.sv
// ----------------------------------------------------------------------------
// lfa_scan
// Find-first-free unit: returns the lowest clear bit of a bitmap word at or
// above a start offset. Shared by every step of the pointer advance.
// ----------------------------------------------------------------------------
module lfa_scan (
  input  logic [lfa_pkg::WORD_W-1:0] word,
  input  logic [lfa_pkg::OFF_W-1:0]  start,
  output logic                       found,
  output logic [lfa_pkg::OFF_W-1:0]  idx
);
  import lfa_pkg::*;

  logic [WORD_W-1:0] cand;

  // free bits at or above the start offset
  assign cand  = ~word & ({WORD_W{1'b1}} << start);
  assign found = |cand;

  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = OFF_W'(i);
      end
    end
  end

endmodule

### rtl/lfa_map.sv
// ----------------------------------------------------------------------------
// lfa_map
// Used-identifier bitmap: a word-wide memory with one read and one write port,
// registered read data, and a clearing sweep of one word per cycle after reset.
// ----------------------------------------------------------------------------
module lfa_map #(
  parameter int NWORDS = 8,
  parameter int WA     = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [WA-1:0]              rd_addr,
  output logic [lfa_pkg::WORD_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [WA-1:0]              wr_addr,
  input  logic [lfa_pkg::WORD_W-1:0] wr_data,
  output logic                       busy
);
  import lfa_pkg::*;

  logic [WORD_W-1:0] mem [NWORDS];
  logic [WA-1:0]     clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr  <= '0;
    end else if (busy) begin
      if (clr == WA'(NWORDS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr <= clr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/lowest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Hands out the lowest free identifier, frees and queries identifiers, over a
// bitmap held in word memory and a pointer to the lowest free entry.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat fields
//  --------+----------------------+-------------------------------------
//  req     | req_valid, req_stall | operation, entity_id
//  rsp     | rsp_valid, rsp_stall | created_id, alive, full_res
//
// Free, query, unused codes and create on a full table: S_READ, then S_EXEC.
// Create: S_READ, S_EXEC, then one S_SCAN step per further bitmap word the
// pointer advance walks; the find-first-free unit takes one word per cycle
// from the single memory read port.
// After reset the bitmap is cleared one word per cycle with req_stall high.
// A request is taken only while the result register is free or drains in
// the same cycle; a stalled result holds.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator #(
  parameter int CAPACITY = lfa_pkg::DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [lfa_pkg::OP_W-1:0] operation,
  input  logic [lfa_pkg::ID_W-1:0] entity_id,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [lfa_pkg::ID_W-1:0] created_id,
  output logic                     alive,
  output logic                     full_res
);
  import lfa_pkg::*;

  localparam int NWORDS = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = $clog2(NWORDS + 1);
  localparam int PW     = CW + OFF_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [CW-1:0] NW_C  = CW'(NWORDS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]        state;
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic              rng;
  logic              go;
  logic [PW-1:0]     ptr;
  logic [CW-1:0]     cur_word;

  logic              accept;
  logic              busy;
  logic              is_create;
  logic              need_mem;
  logic [WA-1:0]     id_word;
  logic [OFF_W-1:0]  id_bit;
  logic [CW-1:0]     ptr_word;
  logic [OFF_W-1:0]  ptr_bit;
  logic [WORD_W-1:0] ptr_mask;
  logic [WORD_W-1:0] id_mask;
  logic [CW-1:0]     nxt;
  logic              nxt_ok;

  logic              rd_en;
  logic [WA-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WA-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [WORD_W-1:0] scan_word;
  logic [OFF_W-1:0]  scan_start;
  logic              found;
  logic [OFF_W-1:0]  idx;
  logic [PW-1:0]     found_ptr;
  logic [PW-1:0]     clamp_ptr;

  assign accept    = req_valid && !req_stall;
  assign req_stall = busy || (state != S_IDLE) || (rsp_valid && rsp_stall);

  assign is_create = (op_r == OP_CREATE);
  assign id_word   = WA'(id_r >> OFF_W);
  assign id_bit    = id_r[OFF_W-1:0];
  assign ptr_word  = ptr[PW-1:OFF_W];
  assign ptr_bit   = ptr[OFF_W-1:0];
  assign ptr_mask  = WORD_W'(1) << ptr_bit;
  assign id_mask   = WORD_W'(1) << id_bit;
  assign nxt       = cur_word + 1'b1;
  assign nxt_ok    = (nxt < NW_C);

  assign need_mem = is_create ? (ptr < CAP_P)
                  : (((op_r == OP_FREE) || (op_r == OP_QUERY)) && rng);

  // memory ports: fetch the target word, then prefetch the next word while scanning
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = is_create ? ptr_word[WA-1:0] : id_word;
    wr_en   = 1'b0;
    wr_addr = id_word;
    wr_data = rd_data & ~id_mask;
    case (state)
      S_READ: begin
        rd_en = need_mem;
      end
      S_EXEC: begin
        if (is_create) begin
          rd_en   = go && nxt_ok;
          rd_addr = nxt[WA-1:0];
          wr_en   = go;
          wr_addr = cur_word[WA-1:0];
          wr_data = rd_data | ptr_mask;
        end else begin
          wr_en = go && (op_r == OP_FREE);
        end
      end
      S_SCAN: begin
        rd_en   = nxt_ok;
        rd_addr = nxt[WA-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign scan_word  = (state == S_EXEC) ? (rd_data | ptr_mask) : rd_data;
  assign scan_start = (state == S_EXEC) ? ptr_bit : '0;
  assign found_ptr  = {cur_word, idx};
  // padding bits past the table read as free: stop at the capacity
  assign clamp_ptr  = (found_ptr >= CAP_P) ? CAP_P : found_ptr;

  lfa_scan u_scan (
    .word  (scan_word),
    .start (scan_start),
    .found (found),
    .idx   (idx)
  );

  lfa_map #(
    .NWORDS (NWORDS),
    .WA     (WA)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_EXEC) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
          if (is_create && go) begin
            if (found) begin
              ptr <= clamp_ptr;
            end else if (!nxt_ok) begin
              ptr <= CAP_P;
            end else begin
              state <= S_SCAN;
            end
          end else if ((op_r == OP_FREE) && go && (32'(id_r) < 32'(ptr))) begin
            ptr <= PW'(id_r);
          end
        end
        S_SCAN: begin
          if (found) begin
            ptr   <= clamp_ptr;
            state <= S_IDLE;
          end else if (!nxt_ok) begin
            ptr   <= CAP_P;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= operation;
      id_r <= entity_id;
      rng  <= (32'(entity_id) < 32'(CAPACITY));
    end
    if (state == S_READ) begin
      go       <= need_mem;
      cur_word <= ptr_word;
    end else if ((state == S_EXEC) || (state == S_SCAN)) begin
      cur_word <= nxt;
    end
  end

  // result beat, written once per request
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      created_id <= (is_create && go) ? ID_W'(ptr) : '0;
      alive      <= (op_r == OP_QUERY) && go && rd_data[id_bit];
      full_res   <= is_create && !go;
    end
  end

endmodule

### rtl/lfa_checker.sv
// ----------------------------------------------------------------------------
// lfa_checker
// Port-level checks on the allocator: a taken request blocks the next, no
// request taken while a result is stuck, stalled results hold, consistent full results.
// ----------------------------------------------------------------------------
module lfa_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_stall,
  input logic                     rsp_valid,
  input logic                     rsp_stall,
  input logic [lfa_pkg::ID_W-1:0] created_id,
  input logic                     alive,
  input logic                     full_res
);
  import lfa_pkg::*;

  // a taken request blocks the next one while it is worked on
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken back to back");

  // no new request while a result beat waits
  a_no_take_on_stuck: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> req_stall)
    else $error("request taken while result stalled");

  // a full indication carries no identifier and no query answer
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && full_res) |-> ((created_id == '0) && !alive))
    else $error("full result with other fields set");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(created_id) && $stable(alive) && $stable(full_res)))
    else $error("stalled result changed");

endmodule

bind lowest_free_id_allocator lfa_checker u_lfa_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .created_id (created_id),
  .alive      (alive),
  .full_res   (full_res)
);

### dv/lowest_free_id_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_tb
// Drives create, free, query and unused requests into the allocator and
// compares every response beat against a bitmap/pointer predictor.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [lfa_pkg::ID_W-1:0] created;
  logic                     alive;
  logic                     full;
} alloc_result_t;

class id_alloc_scoreboard;
  bit            in_use[lfa_pkg::DEF_CAPACITY];
  int unsigned   low_free;
  alloc_result_t pending[$];
  int unsigned   errors;
  int unsigned   n_create, n_full, n_free, n_query, n_other, n_checked;

  function new();
    foreach (in_use[i]) in_use[i] = 1'b0;
    low_free = 0;
    errors   = 0;
  endfunction

  function bit is_full();
    return low_free >= lfa_pkg::DEF_CAPACITY;
  endfunction

  function int pending_count();
    return pending.size();
  endfunction

  // random identifier currently in use, -1 when the table is empty
  function int pick_used_id();
    int ids[$];
    foreach (in_use[i]) if (in_use[i]) ids.push_back(i);
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function void note_request(logic [lfa_pkg::OP_W-1:0] op, logic [lfa_pkg::ID_W-1:0] id);
    alloc_result_t res;
    int unsigned   pos;
    res = '0;
    case (op)
      lfa_pkg::OP_CREATE: begin
        n_create++;
        if (is_full()) begin
          res.full = 1'b1;
          n_full++;
        end else begin
          pos = low_free;
          in_use[pos] = 1'b1;
          res.created = pos[lfa_pkg::ID_W-1:0];
          while (pos < lfa_pkg::DEF_CAPACITY && in_use[pos]) pos++;
          low_free = pos;
        end
      end
      lfa_pkg::OP_FREE: begin
        n_free++;
        if (32'(id) < lfa_pkg::DEF_CAPACITY) begin
          in_use[id] = 1'b0;
          if (32'(id) < low_free) low_free = 32'(id);
        end
      end
      lfa_pkg::OP_QUERY: begin
        n_query++;
        if (32'(id) < lfa_pkg::DEF_CAPACITY) res.alive = in_use[id];
      end
      default: n_other++;
    endcase
    pending.push_back(res);
  endfunction

  function void check_response(logic [lfa_pkg::ID_W-1:0] created, logic alv, logic full);
    alloc_result_t exp_res;
    if (pending.size() == 0) begin
      $display("[%0t] ERROR response beat with nothing outstanding: %s %0d %s %0b %s %0b",
               $time, "created_id", created, "alive", alv, "full_res", full);
      errors++;
      return;
    end
    exp_res = pending.pop_front();
    n_checked++;
    if (created !== exp_res.created) begin
      $display("[%0t] ERROR created_id expected %0d got %0d", $time, exp_res.created, created);
      errors++;
    end
    if (alv !== exp_res.alive) begin
      $display("[%0t] ERROR alive expected %0b got %0b", $time, exp_res.alive, alv);
      errors++;
    end
    if (full !== exp_res.full) begin
      $display("[%0t] ERROR full_res expected %0b got %0b", $time, exp_res.full, full);
      errors++;
    end
  endfunction
endclass

module lowest_free_id_allocator_tb;
  import lfa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int FILL_MAX = 600;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  logic [OP_W-1:0] operation = OP_CREATE;
  logic [ID_W-1:0] entity_id = '0;
  logic            rsp_valid;
  logic            rsp_stall = 1'b0;
  logic [ID_W-1:0] created_id;
  logic            alive;
  logic            full_res;

  id_alloc_scoreboard sb;
  int unsigned        send_idle;
  int unsigned        recv_idle;
  int unsigned        cycles;

  lowest_free_id_allocator #(.CAPACITY(DEF_CAPACITY)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .entity_id (entity_id),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .created_id(created_id),
    .alive     (alive),
    .full_res  (full_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("[%0t] run limit of %0d cycles reached", $time, RUN_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // response side: check the beat taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0)
      sb.check_response(created_id, alive, full_res);
    rsp_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    entity_id <= id;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    sb.note_request(op, id);
  endtask

  // free/query target: a live identifier with live_pct chance, otherwise anything
  function automatic logic [ID_W-1:0] pick_target(input int live_pct);
    int used;
    used = sb.pick_used_id();
    if (used >= 0 && $urandom_range(0, 99) < live_pct) return used[ID_W-1:0];
    return ID_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input mix_t mix);
    int unsigned     roll;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    id   = ID_W'($urandom_range(0, 255));
    case (mix)
      MIX_FILL:
        if (roll < 85) op = OP_CREATE;
        else if (roll < 95) op = OP_QUERY;
        else op = OP_FREE;
      MIX_DRAIN:
        if (roll < 70) op = OP_FREE;
        else if (roll < 90) op = OP_QUERY;
        else op = OP_CREATE;
      default:
        if (roll < 45) op = OP_CREATE;
        else if (roll < 75) op = OP_FREE;
        else if (roll < 95) op = OP_QUERY;
        else op = OP_UNUSED;
    endcase
    if (op == OP_FREE || op == OP_QUERY) id = pick_target(mix == MIX_DRAIN ? 80 : 50);
    send_req(op, id);
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input int n_mixed, input int n_drain);
    int extra;
    int guard;
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n_mixed) send_random(MIX_BALANCED);
    // push to a full table, then keep creating against it for a while
    extra = 0;
    guard = 0;
    while (extra < 8 && guard < FILL_MAX) begin
      if (sb.is_full()) extra++;
      send_random(MIX_FILL);
      guard++;
    end
    repeat (n_drain) send_random(MIX_DRAIN);
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    send_idle = 15;
    recv_idle = 63;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: basic allocation order, pointer lowering, free of a free entry,
    // unused opcode, and both ends of entity_id
    send_req(OP_QUERY,  8'd255);
    send_req(OP_CREATE, 8'd255);
    send_req(OP_CREATE, 8'd0);
    send_req(OP_CREATE, 8'd170);
    send_req(OP_QUERY,  8'd1);
    send_req(OP_QUERY,  8'd0);
    send_req(OP_FREE,   8'd1);
    send_req(OP_QUERY,  8'd1);
    send_req(OP_CREATE, 8'd85);
    send_req(OP_FREE,   8'd0);
    send_req(OP_FREE,   8'd0);
    send_req(OP_FREE,   8'd200);
    send_req(OP_FREE,   8'd255);
    send_req(OP_UNUSED, 8'd255);
    send_req(OP_UNUSED, 8'd0);
    send_req(OP_CREATE, 8'd0);
    send_req(OP_CREATE, 8'd255);
    send_req(OP_QUERY,  8'd3);
    send_req(OP_QUERY,  8'd128);
    send_req(OP_QUERY,  8'd255);

    run_phase(15, 63, 150, 60);
    run_phase(63, 15, 150, 60);
    run_phase(0, 0, 150, 60);
    req_valid <= 1'b0;

    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d creates (%0d on a full table), %0d frees, %0d queries, %0d unused",
             sb.n_create, sb.n_full, sb.n_free, sb.n_query, sb.n_other);
    $display("%0d response beats checked, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### sim.f
rtl/lfa_pkg.sv
rtl/lfa_scan.sv
rtl/lfa_map.sv
rtl/lowest_free_id_allocator.sv
rtl/lfa_checker.sv
dv/lowest_free_id_allocator_tb.sv
